// ===== rtl/core/dmc_pkg.sv =====
// Shared types and constants for the depth-first maze carver.
// No dependencies; every other file of the block imports this package.
package dmc_pkg;

  // Grid geometry
  localparam int GRID_MAX = 16;
  localparam int COORD_W  = 4;
  localparam int CELLS    = GRID_MAX * GRID_MAX;
  localparam int IDX_W    = $clog2(CELLS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int SIZE_W   = 5;
  localparam int CELL_W   = 5;
  localparam int WALL_W   = 4;

  // Cell word: bit4 visited, bits 3:0 walls
  localparam logic [CELL_W-1:0] VISITED   = 5'h10;
  localparam logic [WALL_W-1:0] ALL_WALLS = 4'hF;
  localparam logic [WALL_W-1:0] W_XP      = 4'b0001;
  localparam logic [WALL_W-1:0] W_XM      = 4'b0010;
  localparam logic [WALL_W-1:0] W_YP      = 4'b0100;
  localparam logic [WALL_W-1:0] W_YM      = 4'b1000;

  // Operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Carve directions
  typedef enum logic [1:0] {
    DIR_XP = 2'd0,
    DIR_YM = 2'd1,
    DIR_XM = 2'd2,
    DIR_YP = 2'd3
  } dir_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;   // capture input transaction
    logic start;      // wall in all cells, seed stack
    logic here_rd;    // read top-of-stack cell
    logic here_cap;   // keep top cell word
    logic nbr_rd;     // read neighbor cell
    logic k_inc;      // next direction
    logic wr_nbr;     // write carved neighbor
    logic wr_here;    // write top cell, push neighbor
    logic pop;        // pop stack, record exit
    logic stk_rd;     // read new top-of-stack entry
    logic stk_cap;    // load top from stack entry
    logic cell_rd;    // read requested cell
    logic cell_cap;   // keep requested walls
    logic out_load;   // load result register
  } dmc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       stack_empty;
    logic       nbr_inb;
    logic       nbr_visited;
    logic       k_last;
  } dmc_stat_t;

endpackage

// ===== rtl/core/dmc_in_if.sv =====
// Input channel of the maze carver: valid/ready plus one operation.
// Depends on dmc_pkg for field widths.
interface dmc_in_if import dmc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [1:0]         rand_dir;
  logic [COORD_W-1:0] read_x;
  logic [COORD_W-1:0] read_y;

  modport source (output valid, op, rand_dir, read_x, read_y, input ready);
  modport sink   (input valid, op, rand_dir, read_x, read_y, output ready);
endinterface

// ===== rtl/core/dmc_out_if.sv =====
// Result channel of the maze carver: valid/ready plus status of one operation.
// Depends on dmc_pkg for field widths.
interface dmc_out_if import dmc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WALL_W-1:0]  cell_walls;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic               carved;
  logic               done_res;
  logic [COORD_W-1:0] finish_x;
  logic [COORD_W-1:0] finish_y;
  logic               finish_found;

  modport source (output valid, cell_walls, cur_x, cur_y, carved, done_res,
                  finish_x, finish_y, finish_found, input ready);
  modport sink   (input valid, cell_walls, cur_x, cur_y, carved, done_res,
                  finish_x, finish_y, finish_found, output ready);
endinterface

// ===== rtl/core/dmc_ctrl.sv =====
// Sequencing state machine of the maze carver.
// Depends on dmc_pkg; drives dmc_datapath through dmc_cmd_t.
module dmc_ctrl import dmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dmc_stat_t stat,
  output dmc_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_START, S_HERE_RD, S_HERE_CAP, S_TRY, S_CHK,
    S_WR_NBR, S_WR_HERE, S_POP, S_STK_RD, S_STK_CAP, S_CELL_RD, S_CELL_CAP,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (op_t'(stat.op))
          OP_START: state_nxt = S_START;
          OP_STEP:  state_nxt = stat.stack_empty ? S_FINISH : S_HERE_RD;
          OP_READ:  state_nxt = S_CELL_RD;
          default:  state_nxt = S_FINISH;
        endcase
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_FINISH;
      end
      S_HERE_RD: begin
        cmd.here_rd = 1'b1;
        state_nxt   = S_HERE_CAP;
      end
      S_HERE_CAP: begin
        cmd.here_cap = 1'b1;
        state_nxt    = S_TRY;
      end
      // Bounds check for the current direction; read the neighbor if inside
      S_TRY: begin
        if (stat.nbr_inb) begin
          cmd.nbr_rd = 1'b1;
          state_nxt  = S_CHK;
        end else if (stat.k_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_CHK: begin
        if (!stat.nbr_visited) begin
          state_nxt = S_WR_NBR;
        end else if (stat.k_last) begin
          state_nxt = S_POP;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_TRY;
        end
      end
      S_WR_NBR: begin
        cmd.wr_nbr = 1'b1;
        state_nxt  = S_WR_HERE;
      end
      S_WR_HERE: begin
        cmd.wr_here = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_STK_RD;
      end
      // Stack now holds one entry fewer; empty means top is already zero
      S_STK_RD: begin
        if (stat.stack_empty) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.stk_rd = 1'b1;
          state_nxt  = S_STK_CAP;
        end
      end
      S_STK_CAP: begin
        cmd.stk_cap = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = S_CELL_CAP;
      end
      S_CELL_CAP: begin
        cmd.cell_cap = 1'b1;
        state_nxt    = S_FINISH;
      end
      // Wait for the result register to free up
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/dmc_datapath.sv =====
// Datapath of the maze carver: cell store, path stack, coordinates, result register.
// Depends on dmc_pkg; commanded by dmc_ctrl.
module dmc_datapath import dmc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dmc_cmd_t           cmd,
  output dmc_stat_t          stat,
  input  logic [1:0]         in_op,
  input  logic [1:0]         in_rand_dir,
  input  logic [COORD_W-1:0] in_read_x,
  input  logic [COORD_W-1:0] in_read_y,
  input  logic               cfg_we,
  input  logic [SIZE_W-1:0]  cfg_wdata,
  output logic [WALL_W-1:0]  out_cell_walls,
  output logic [COORD_W-1:0] out_cur_x,
  output logic [COORD_W-1:0] out_cur_y,
  output logic               out_carved,
  output logic               out_done_res,
  output logic [COORD_W-1:0] out_finish_x,
  output logic [COORD_W-1:0] out_finish_y,
  output logic               out_finish_found
);

  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(GRID_MAX);
  localparam logic [SIZE_W-1:0] ONE5     = SIZE_W'(1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(CELLS);

  // Latched input transaction
  logic [1:0]         op_r;
  logic [1:0]         dir_r;
  logic [COORD_W-1:0] rx_r, ry_r;
  logic [1:0]         k_r;

  // Control-side state
  logic [SIZE_W-1:0]  grid_r;
  logic [CNT_W-1:0]   count_r;
  logic [COORD_W-1:0] top_x_r, top_y_r;
  logic [COORD_W-1:0] exit_x_r, exit_y_r;
  logic               exit_known_r;
  logic               carved_r;
  logic [WALL_W-1:0]  walls_r;
  logic [CELL_W-1:0]  here_r;

  // Cell store with per-entry valid bits; invalid reads as all walls
  logic [CELL_W-1:0]  cell_mem [CELLS];
  logic [CELLS-1:0]   cell_vld_r;
  logic [CELL_W-1:0]  cell_rdata_r;
  logic               cell_rvld_r;
  logic [CELL_W-1:0]  cell_eff;

  // Path stack
  logic [IDX_W-1:0]   stk_mem [CELLS];
  logic [IDX_W-1:0]   stk_rdata_r;

  // Neighbor decode
  logic [SIZE_W-1:0]  n_eff, tx5, ty5;
  logic [1:0]         dir_cur;
  logic               nbr_inb;
  logic [COORD_W-1:0] nx, ny;
  logic [WALL_W-1:0]  here_clr, there_clr;
  logic [IDX_W-1:0]   here_idx, nbr_idx, req_idx;

  // Memory port muxes
  logic               rd_en, wr_en;
  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic [CELL_W-1:0]  wr_data;
  logic               push_ok;
  logic [CNT_W-1:0]   count_dec;

  // Effective grid size, clamped to the legal range
  always_comb begin
    if (grid_r < SIZE_MIN) begin
      n_eff = SIZE_MIN;
    end else if (grid_r > SIZE_MAX) begin
      n_eff = SIZE_MAX;
    end else begin
      n_eff = grid_r;
    end
  end

  assign dir_cur  = dir_r + k_r;
  assign tx5      = {1'b0, top_x_r};
  assign ty5      = {1'b0, top_y_r};
  assign here_idx = {top_y_r, top_x_r};
  assign nbr_idx  = {ny, nx};
  assign req_idx  = {ry_r, rx_r};

  // Neighbor coordinates, bounds and wall masks for the direction under test
  always_comb begin
    nx        = top_x_r;
    ny        = top_y_r;
    nbr_inb   = 1'b0;
    here_clr  = '0;
    there_clr = '0;
    unique case (dir_t'(dir_cur))
      DIR_XP: begin
        nbr_inb   = (tx5 + ONE5) < n_eff;
        nx        = top_x_r + COORD_W'(1);
        here_clr  = W_XP;
        there_clr = W_XM;
      end
      DIR_YM: begin
        nbr_inb   = (top_y_r != '0) && ((ty5 - ONE5) < n_eff);
        ny        = top_y_r - COORD_W'(1);
        here_clr  = W_YM;
        there_clr = W_YP;
      end
      DIR_XM: begin
        nbr_inb   = (top_x_r != '0) && ((tx5 - ONE5) < n_eff);
        nx        = top_x_r - COORD_W'(1);
        here_clr  = W_XM;
        there_clr = W_XP;
      end
      DIR_YP: begin
        nbr_inb   = (ty5 + ONE5) < n_eff;
        ny        = top_y_r + COORD_W'(1);
        here_clr  = W_YP;
        there_clr = W_YM;
      end
      default: nbr_inb = 1'b0;
    endcase
  end

  assign cell_eff = cell_rvld_r ? cell_rdata_r : {1'b0, ALL_WALLS};

  // Status to the controller
  assign stat.op          = op_r;
  assign stat.stack_empty = (count_r == '0);
  assign stat.nbr_inb     = nbr_inb;
  assign stat.nbr_visited = |(cell_eff & VISITED);
  assign stat.k_last      = (k_r == 2'd3);

  // Cell store port selection
  always_comb begin
    rd_en   = cmd.here_rd | cmd.nbr_rd | cmd.cell_rd;
    rd_addr = req_idx;
    if (cmd.here_rd) begin
      rd_addr = here_idx;
    end else if (cmd.nbr_rd) begin
      rd_addr = nbr_idx;
    end
    wr_en   = cmd.start | cmd.wr_nbr | cmd.wr_here;
    wr_addr = here_idx;
    wr_data = here_r & ~{1'b0, here_clr};
    if (cmd.start) begin
      wr_addr = '0;
      wr_data = VISITED | {1'b0, ALL_WALLS};
    end else if (cmd.wr_nbr) begin
      wr_addr = nbr_idx;
      wr_data = (cell_eff & ~{1'b0, there_clr}) | VISITED;
    end
  end

  assign push_ok   = (count_r < CNT_FULL);
  assign count_dec = count_r - CNT_W'(1);

  // Cell store memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cell_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      cell_rdata_r <= cell_mem[rd_addr];
      cell_rvld_r  <= cell_vld_r[rd_addr];
    end
  end

  // Path stack memory
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      stk_mem[0] <= '0;
    end else if (cmd.wr_here && push_ok) begin
      stk_mem[count_r[IDX_W-1:0]] <= nbr_idx;
    end
    if (cmd.stk_rd) begin
      stk_rdata_r <= stk_mem[count_dec[IDX_W-1:0]];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= in_op;
      dir_r <= in_rand_dir;
      rx_r  <= in_read_x;
      ry_r  <= in_read_y;
    end
    if (cmd.here_cap) begin
      here_r <= cell_eff;
    end
    if (cmd.out_load) begin
      out_cell_walls   <= walls_r;
      out_cur_x        <= top_x_r;
      out_cur_y        <= top_y_r;
      out_carved       <= carved_r;
      out_done_res     <= (count_r == '0);
      out_finish_x     <= exit_x_r;
      out_finish_y     <= exit_y_r;
      out_finish_found <= exit_known_r;
    end
  end

  // Control state: valid bits, stack pointer, top cell, exit record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r       <= SIZE_MAX;
      cell_vld_r   <= '0;
      count_r      <= '0;
      top_x_r      <= '0;
      top_y_r      <= '0;
      exit_x_r     <= '0;
      exit_y_r     <= '0;
      exit_known_r <= 1'b0;
      k_r          <= '0;
      carved_r     <= 1'b0;
      walls_r      <= '0;
    end else begin
      if (cfg_we) begin
        grid_r <= cfg_wdata;
      end
      if (cmd.latch_in) begin
        k_r      <= '0;
        carved_r <= 1'b0;
        walls_r  <= '0;
      end else if (cmd.k_inc) begin
        k_r <= k_r + 2'd1;
      end
      if (cmd.cell_cap) begin
        walls_r <= cell_eff[WALL_W-1:0];
      end
      // Start: everything walled in, only cell (0,0) written
      if (cmd.start) begin
        cell_vld_r   <= CELLS'(1);
        count_r      <= CNT_W'(1);
        top_x_r      <= '0;
        top_y_r      <= '0;
        exit_x_r     <= '0;
        exit_y_r     <= '0;
        exit_known_r <= 1'b0;
      end else if (wr_en) begin
        cell_vld_r[wr_addr] <= 1'b1;
      end
      // Push the carved neighbor
      if (cmd.wr_here) begin
        carved_r <= 1'b1;
        if (push_ok) begin
          count_r <= count_r + CNT_W'(1);
          top_x_r <= nx;
          top_y_r <= ny;
        end
      end
      // Dead end: pop, first one becomes the exit
      if (cmd.pop) begin
        count_r <= count_dec;
        if (!exit_known_r) begin
          exit_x_r     <= top_x_r;
          exit_y_r     <= top_y_r;
          exit_known_r <= 1'b1;
        end
        if (count_dec == '0) begin
          top_x_r <= '0;
          top_y_r <= '0;
        end
      end
      if (cmd.stk_cap) begin
        top_x_r <= stk_rdata_r[COORD_W-1:0];
        top_y_r <= stk_rdata_r[IDX_W-1:COORD_W];
      end
    end
  end

endmodule

// ===== rtl/core/dfs_maze_carver.sv =====
// Top level of the depth-first maze carver: controller plus datapath.
// Depends on dmc_pkg, dmc_in_if, dmc_out_if, dmc_ctrl and dmc_datapath.
//
//   channel   direction  handshake     carries
//   in_if     sink       valid/ready   op, rand_dir, read_x, read_y
//   out_if    source     valid/ready   cell_walls, cur_x/y, carved, done_res, finish_*
//   cfg_*     sink       cfg_we        grid_size (5 bits)
//
// One operation at a time. Start runs S_START, a read S_CELL_RD and S_CELL_CAP, and a
// step on an empty stack or a spare code goes straight to S_FINISH. A step tries each
// direction in S_TRY, reading an in-bounds neighbor from the single-port cell store
// for S_CHK; a carve then writes neighbor and top, a dead end pops and reloads the top.
// Reset is synchronous; cell store valid bits clear at once, so no sweep is needed.
// A result waiting in the output register does not block the next transaction;
// the controller stalls only when a second result is ready before the first is taken.
module dfs_maze_carver import dmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dmc_in_if.sink            in_if,
  dmc_out_if.source         out_if,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);

  dmc_cmd_t  cmd;
  dmc_stat_t stat;

  // Sequencer
  dmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and arithmetic
  dmc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_if.op),
    .in_rand_dir      (in_if.rand_dir),
    .in_read_x        (in_if.read_x),
    .in_read_y        (in_if.read_y),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_cell_walls   (out_if.cell_walls),
    .out_cur_x        (out_if.cur_x),
    .out_cur_y        (out_if.cur_y),
    .out_carved       (out_if.carved),
    .out_done_res     (out_if.done_res),
    .out_finish_x     (out_if.finish_x),
    .out_finish_y     (out_if.finish_y),
    .out_finish_found (out_if.finish_found)
  );

endmodule

// ===== rtl/core/dmc_checker.sv =====
// Port-level checks for dfs_maze_carver, attached with a bind.
// Depends on dmc_pkg for field widths.
module dmc_checker import dmc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               carved,
  input logic               done_res,
  input logic [COORD_W-1:0] cur_x,
  input logic [COORD_W-1:0] cur_y
);

  // No result comes out of reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // One transaction at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // A carved passage always leaves a cell on the stack
  a_carve_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(carved && done_res))
    else $error("carved with empty stack");

  // Empty stack reports the origin as current cell
  a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && done_res) |-> (cur_x == '0 && cur_y == '0))
    else $error("nonzero current cell with empty stack");

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind dfs_maze_carver dmc_checker u_dmc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .carved    (out_if.carved),
  .done_res  (out_if.done_res),
  .cur_x     (out_if.cur_x),
  .cur_y     (out_if.cur_y)
);

// ===== tb/tb.sv =====
// Self-checking testbench for dfs_maze_carver: a predictor carves the same maze per transaction.
// Depends on dmc_pkg, dmc_in_if, dmc_out_if and the dfs_maze_carver RTL.
module tb;
  import dmc_pkg::*;

  localparam logic [1:0] OP_SPARE   = 2'd3;  // unused code, reports status only
  localparam int ITEM_TARGET        = 1450;
  localparam int LOG_LIMIT          = 10;
  localparam int DRAIN_CYCLES       = 32;
  localparam int RUN_LIMIT          = 2000000;

  typedef struct packed {
    logic [1:0]         op;
    dir_t               dir;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
  } maze_cmd_t;

  typedef struct packed {
    logic [WALL_W-1:0]  cell_walls;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic               carved;
    logic               done_res;
    logic [COORD_W-1:0] finish_x;
    logic [COORD_W-1:0] finish_y;
    logic               finish_found;
  } maze_status_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  dmc_in_if  op_ch ();
  dmc_out_if res_ch ();

  dfs_maze_carver DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (op_ch),
    .out_if    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: cell words, path stack, exit record, grid register
  logic [CELL_W-1:0]  cell_mem [CELLS];
  logic [IDX_W-1:0]   path_mem [CELLS];
  logic [CNT_W-1:0]   path_depth;
  logic [COORD_W-1:0] exit_x_q;
  logic [COORD_W-1:0] exit_y_q;
  logic               exit_seen;
  logic [SIZE_W-1:0]  grid_reg;

  maze_cmd_t    pending_ops [$];
  maze_status_t status_due [$];
  maze_cmd_t    sent_op;

  int queued_total  = 0;
  int fail_cnt      = 0;
  int checked_cnt   = 0;
  int start_cnt     = 0;
  int step_cnt      = 0;
  int carve_cnt     = 0;
  int read_cnt      = 0;
  int maze_done_cnt = 0;
  int grid_writes   = 0;

  // Clock, and every block input known from time zero
  initial begin
    op_ch.valid    = 1'b0;
    op_ch.op       = OP_START;
    op_ch.rand_dir = DIR_XP;
    op_ch.read_x   = '0;
    op_ch.read_y   = '0;
    res_ch.ready   = 1'b0;
    forever #2 clk = ~clk;
  end

  // Out-of-range sizes clamp to the legal span
  function automatic int eff_grid(logic [SIZE_W-1:0] v);
    if (v < 2) return 2;
    if (v > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  function automatic void maze_clear();
    for (int i = 0; i < CELLS; i++) begin
      cell_mem[i] = {1'b0, ALL_WALLS};
      path_mem[i] = '0;
    end
    path_depth = '0;
    exit_x_q   = '0;
    exit_y_q   = '0;
    exit_seen  = 1'b0;
    grid_reg   = SIZE_W'(GRID_MAX);
  endfunction

  // Applies one transaction to the predicted maze and returns the status it reports
  function automatic maze_status_t maze_status_after(maze_cmd_t c);
    maze_status_t       r;
    int                 n, x, y, nx, ny;
    dir_t               d;
    logic [WALL_W-1:0]  here_m, there_m;
    logic               ok, hit;
    logic [IDX_W-1:0]   top, nb;
    r = '0;
    n = eff_grid(grid_reg);
    case (c.op)
      OP_START: begin
        start_cnt++;
        for (int i = 0; i < CELLS; i++) cell_mem[i] = {1'b0, ALL_WALLS};
        cell_mem[0] = cell_mem[0] | VISITED;
        path_mem[0] = '0;
        path_depth  = CNT_W'(1);
        exit_x_q    = '0;
        exit_y_q    = '0;
        exit_seen   = 1'b0;
      end
      OP_STEP: begin
        step_cnt++;
        if (path_depth != 0) begin
          top     = path_mem[path_depth - 1];
          x       = int'(top) % GRID_MAX;
          y       = int'(top) / GRID_MAX;
          hit     = 1'b0;
          here_m  = '0;
          there_m = '0;
          for (int k = 0; k < 4; k++) begin
            if (!hit) begin
              d  = dir_t'(c.dir + k[1:0]);
              ok = 1'b0;
              nx = x;
              ny = y;
              case (d)
                DIR_XP: if (x + 1 < n) begin
                  ok = 1'b1; nx = x + 1; here_m = W_XP; there_m = W_XM;
                end
                DIR_YM: if (y != 0 && y - 1 < n) begin
                  ok = 1'b1; ny = y - 1; here_m = W_YM; there_m = W_YP;
                end
                DIR_XM: if (x != 0 && x - 1 < n) begin
                  ok = 1'b1; nx = x - 1; here_m = W_XM; there_m = W_XP;
                end
                default: if (y + 1 < n) begin
                  ok = 1'b1; ny = y + 1; here_m = W_YP; there_m = W_YM;
                end
              endcase
              nb = IDX_W'(ny * GRID_MAX + nx);
              if (ok && (cell_mem[nb] & VISITED) == '0) begin
                cell_mem[top] = cell_mem[top] & ~{1'b0, here_m};
                cell_mem[nb]  = (cell_mem[nb] & ~{1'b0, there_m}) | VISITED;
                if (path_depth < CELLS) begin
                  path_mem[path_depth] = nb;
                  path_depth++;
                end
                hit = 1'b1;
              end
            end
          end
          if (hit) begin
            r.carved = 1'b1;
            carve_cnt++;
          end else begin
            // dead end: pop, and the first one becomes the exit
            path_depth--;
            if (path_depth == 0) maze_done_cnt++;
            if (!exit_seen) begin
              exit_x_q  = COORD_W'(x);
              exit_y_q  = COORD_W'(y);
              exit_seen = 1'b1;
            end
          end
        end
      end
      OP_READ: begin
        read_cnt++;
        r.cell_walls = cell_mem[{c.ry, c.rx}][WALL_W-1:0];
      end
      default: ;
    endcase
    if (path_depth != 0) begin
      top     = path_mem[path_depth - 1];
      r.cur_x = COORD_W'(int'(top) % GRID_MAX);
      r.cur_y = COORD_W'(int'(top) / GRID_MAX);
    end
    r.done_res     = (path_depth == 0);
    r.finish_x     = exit_x_q;
    r.finish_y     = exit_y_q;
    r.finish_found = exit_seen;
    return r;
  endfunction

  function automatic string status_text(maze_status_t s);
    return $sformatf("walls=%h top=(%0d,%0d) carved=%0b empty=%0b exit=(%0d,%0d) known=%0b",
                     s.cell_walls, s.cur_x, s.cur_y, s.carved, s.done_res,
                     s.finish_x, s.finish_y, s.finish_found);
  endfunction

  // Driver: bursts of random length with random gaps, fed from pending_ops
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (op_ch.valid && op_ch.ready) status_due.push_back(maze_status_after(sent_op));
      if (!op_ch.valid || op_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          op_ch.valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          sent_op = pending_ops.pop_front();
          op_ch.valid    <= 1'b1;
          op_ch.op       <= sent_op.op;
          op_ch.rand_dir <= sent_op.dir;
          op_ch.read_x   <= sent_op.rx;
          op_ch.read_y   <= sent_op.ry;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(16, 1);
            gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left--;
          end
        end else begin
          op_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction, then picks the next stall
  int         rx_mode    = 0;
  int         rx_left    = 0;
  logic [7:0] rx_pattern = 8'b1011_0010;

  always @(posedge clk) begin : monitor
    maze_status_t got, want;
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        got.cell_walls   = res_ch.cell_walls;
        got.cur_x        = res_ch.cur_x;
        got.cur_y        = res_ch.cur_y;
        got.carved       = res_ch.carved;
        got.done_res     = res_ch.done_res;
        got.finish_x     = res_ch.finish_x;
        got.finish_y     = res_ch.finish_y;
        got.finish_found = res_ch.finish_found;
        if (status_due.size() == 0) begin
          if (fail_cnt < LOG_LIMIT)
            $display("%0t: unexpected result %s", $time, status_text(got));
          fail_cnt++;
        end else begin
          want = status_due.pop_front();
          checked_cnt++;
          if (got !== want) begin
            if (fail_cnt < LOG_LIMIT) begin
              $display("%0t: mismatch on result %0d", $time, checked_cnt);
              $display("  expected %s", status_text(want));
              $display("  actual   %s", status_text(got));
            end
            fail_cnt++;
          end
        end
      end
      // stall modes: always ready, coin flip, mostly stalled, fixed rotating pattern
      if (rx_left == 0) begin
        rx_mode = $urandom_range(3, 0);
        rx_left = $urandom_range(80, 5);
      end else begin
        rx_left--;
      end
      rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
      case (rx_mode)
        0:       res_ch.ready <= 1'b1;
        1:       res_ch.ready <= 1'($urandom_range(1, 0));
        2:       res_ch.ready <= ($urandom_range(3, 0) == 0);
        default: res_ch.ready <= rx_pattern[0];
      endcase
    end
  end

  task automatic push_op(logic [1:0] op, dir_t dir, logic [COORD_W-1:0] rx,
                         logic [COORD_W-1:0] ry);
    maze_cmd_t c;
    c.op  = op;
    c.dir = dir;
    c.rx  = rx;
    c.ry  = ry;
    pending_ops.push_back(c);
    queued_total++;
  endtask

  function automatic dir_t any_dir();
    return dir_t'($urandom_range(3, 0));
  endfunction

  // Idle means nothing queued, nothing offered and nothing outstanding
  task automatic wait_idle();
    @(negedge clk);
    while (pending_ops.size() != 0 || op_ch.valid || status_due.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_grid(logic [SIZE_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    grid_reg  = v;
    grid_writes++;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(19, 0);
    if (r < 1)  return SIZE_W'($urandom_range(1, 0));
    if (r < 14) return SIZE_W'($urandom_range(6, 2));
    if (r < 18) return SIZE_W'($urandom_range(12, 7));
    return SIZE_W'($urandom_range(31, 13));
  endfunction

  // Carve steps with reads, spare codes and the odd restart mixed in
  task automatic queue_walk(int steps, int n);
    int r;
    for (int i = 0; i < steps; i++) begin
      // the item budget also caps the last maze
      if (queued_total >= ITEM_TARGET) break;
      r = $urandom_range(99, 0);
      if (r < 15) begin
        if ($urandom_range(3, 0) != 0)
          push_op(OP_READ, any_dir(), COORD_W'($urandom_range(n - 1, 0)),
                  COORD_W'($urandom_range(n - 1, 0)));
        else
          push_op(OP_READ, any_dir(), COORD_W'($urandom), COORD_W'($urandom));
      end else if (r < 18) begin
        push_op(OP_SPARE, any_dir(), COORD_W'($urandom), COORD_W'($urandom));
      end else if (r < 19) begin
        push_op(OP_START, any_dir(), COORD_W'($urandom), COORD_W'($urandom));
      end
      push_op(OP_STEP, any_dir(), COORD_W'($urandom), COORD_W'($urandom));
    end
  endtask

  // Stimulus
  initial begin : stimulus
    logic [SIZE_W-1:0] size_plan [$];
    logic [SIZE_W-1:0] gsz;
    int                n, steps, phase;
    size_plan = '{5'd31, 5'd1, 5'd3, 5'd2, 5'd7};
    maze_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // no maze yet: steps and reads on the reset store, spare code
    push_op(OP_STEP, DIR_XP, 4'd0, 4'd0);
    push_op(OP_STEP, DIR_YP, 4'd15, 4'd15);
    push_op(OP_READ, DIR_XM, 4'd0, 4'd0);
    push_op(OP_READ, DIR_YM, 4'd15, 4'd15);
    push_op(OP_READ, DIR_XP, 4'd15, 4'd0);
    push_op(OP_READ, DIR_YP, 4'd0, 4'd15);
    push_op(OP_SPARE, DIR_YP, 4'd15, 4'd15);
    // full-size maze: one step per start direction, then restart mid-maze
    push_op(OP_START, DIR_XP, 4'd0, 4'd0);
    push_op(OP_STEP, DIR_XP, 4'd0, 4'd0);
    push_op(OP_STEP, DIR_YM, 4'd0, 4'd0);
    push_op(OP_STEP, DIR_XM, 4'd0, 4'd0);
    push_op(OP_STEP, DIR_YP, 4'd0, 4'd0);
    push_op(OP_READ, DIR_XP, 4'd0, 4'd0);
    push_op(OP_READ, DIR_XP, 4'd1, 4'd0);
    push_op(OP_SPARE, DIR_XP, 4'd0, 4'd0);
    push_op(OP_START, DIR_YM, 4'd9, 4'd6);
    push_op(OP_STEP, DIR_YM, 4'd0, 4'd0);
    wait_idle();

    // size below range acts as 2: finish the maze, then step on an empty stack
    set_grid(5'd0);
    push_op(OP_START, DIR_XP, 4'd0, 4'd0);
    for (int i = 0; i < 8; i++) push_op(OP_STEP, any_dir(), 4'd0, 4'd0);
    push_op(OP_READ, DIR_XP, 4'd1, 4'd1);
    push_op(OP_READ, DIR_XP, 4'd2, 4'd0);

    // random mazes, some resized half way
    phase = 0;
    while (queued_total < ITEM_TARGET) begin
      wait_idle();
      gsz = (phase < size_plan.size()) ? size_plan[phase] : pick_size();
      set_grid(gsz);
      n     = eff_grid(gsz);
      steps = 2 * n * n + $urandom_range(2, 0);
      push_op(OP_START, any_dir(), COORD_W'($urandom), COORD_W'($urandom));
      if ($urandom_range(3, 0) == 0) begin
        queue_walk(steps / 2, n);
        wait_idle();
        gsz = pick_size();
        set_grid(gsz);
        n = eff_grid(gsz);
        queue_walk(2 * n * n, n);
      end else begin
        queue_walk(steps, n);
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (status_due.size() != 0) begin
      $display("%0d results never arrived", status_due.size());
      fail_cnt += status_due.size();
    end
    $display("covered %0d transactions (%0d checked) over %0d grid writes, %0d maze phases",
             queued_total, checked_cnt, grid_writes, phase);
    $display("  %0d starts, %0d steps (%0d carved), %0d reads, %0d mazes completed",
             start_cnt, step_cnt, carve_cnt, read_cnt, maze_done_cnt);
    if (fail_cnt == 0) begin
      $display("dfs_maze_carver regression: pass");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("dfs_maze_carver regression: fail");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #RUN_LIMIT;
    $display("timeout with %0d results outstanding", status_due.size());
    $display("dfs_maze_carver regression: fail");
    $finish;
  end

endmodule

// ===== dfs_maze_carver.f =====
rtl/core/dmc_pkg.sv
rtl/core/dmc_in_if.sv
rtl/core/dmc_out_if.sv
rtl/core/dmc_ctrl.sv
rtl/core/dmc_datapath.sv
rtl/core/dfs_maze_carver.sv
rtl/core/dmc_checker.sv
tb/tb.sv
